@@ hdl/bitmap_collision_map_carver_macros.svh @@
// Assertion macros shared by the collision map carver RTL.
`ifndef BITMAP_COLLISION_MAP_CARVER_MACROS_SVH
`define BITMAP_COLLISION_MAP_CARVER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge out of reset.
`define BCMC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define BCMC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define BCMC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BCMC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/bcmc_pkg.sv @@
// Shared constants for the collision map carver.
`timescale 1ns / 1ps
`default_nettype none

package bcmc_pkg;

    // field widths
    localparam int KIND_W    = 2;
    localparam int COORD_W   = 12;
    localparam int RADIUS_W  = 8;
    localparam int ALPHA_W   = 8;
    localparam int COUNT_W   = 17;
    localparam int CFG_IDX_W = 1;

    // signed working width: coordinate minus origin, plus or minus radius
    localparam int WK_W = 15;
    // signed width of a distance component, |d| <= 256
    localparam int D_W  = 10;
    // squared distance component, <= 65536
    localparam int SQ_W = 17;
    // squared radius, <= 65025
    localparam int R2_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CARVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

endpackage

`default_nettype wire

@@ hdl/bcmc_if.sv @@
// Handshake interfaces for the item, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface bcmc_in_if;
    import bcmc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;
    logic [RADIUS_W-1:0]        radius;
    logic [ALPHA_W-1:0]         pixel_alpha;
    modport source (output valid, kind, x_coord, y_coord, radius, pixel_alpha,
                    input ready);
    modport sink   (input valid, kind, x_coord, y_coord, radius, pixel_alpha,
                    output ready);
endinterface

interface bcmc_out_if;
    import bcmc_pkg::*;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [COUNT_W-1:0] cleared_count;
    modport source (output valid, hit, cleared_count, input ready);
    modport sink   (input valid, hit, cleared_count, output ready);
endinterface

interface bcmc_cfg_if;
    import bcmc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CFG_IDX_W-1:0]       index;
    logic signed [COORD_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/bcmc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bcmc_ram #(
    parameter int WIDTH  = 1,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/bitmap_collision_map_carver.sv @@
// Top level of the collision map carver: sequencer, shared multiplier, map RAM.
//
//  channel   modport             word contents
//  --------  ------------------  ----------------------------------------------
//  i_cfg     bcmc_cfg_if.sink    index (0 origin_x, 1 origin_y), data
//  i_item    bcmc_in_if.sink     kind, x_coord, y_coord, radius, pixel_alpha
//  o_res     bcmc_out_if.source  hit, cleared_count
//
//  After reset the map RAM is swept clear, one pixel a cycle. Load steps through prep,
//  address and access; test adds a wait for its read data; an off-map or unused item
//  goes from prep to the result. Carve walks the clipped box, or skips it if empty: one
//  map RAM read per pixel, its clear written the next cycle, one setup per row.
//  One item is worked at a time; the result register lets the next word in
//  while the last result waits on o_res.ready.
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_collision_map_carver_macros.svh"

module bitmap_collision_map_carver #(
    parameter int MAP_W = 256,
    parameter int MAP_H = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bcmc_cfg_if.sink           i_cfg,
    bcmc_in_if.sink            i_item,
    bcmc_out_if.source         o_res
);

    import bcmc_pkg::*;

    localparam int DEPTH = MAP_W * MAP_H;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [WK_W-1:0] MAP_W_S = WK_W'(MAP_W);
    localparam logic signed [WK_W-1:0] MAP_H_S = WK_W'(MAP_H);
    localparam logic [AW-1:0]          LAST_A  = AW'(DEPTH - 1);

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_PREP  = 15'b000000000000100,
        S_ADDR  = 15'b000000000001000,
        S_ACC   = 15'b000000000010000,
        S_WAIT  = 15'b000000000100000,
        S_MR    = 15'b000000001000000,
        S_MX    = 15'b000000010000000,
        S_MY    = 15'b000000100000000,
        S_MB    = 15'b000001000000000,
        S_BASE  = 15'b000010000000000,
        S_ROW   = 15'b000100000000000,
        S_SCAN  = 15'b001000000000000,
        S_DRAIN = 15'b010000000000000,
        S_RES   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic signed [COORD_W-1:0] r_origin_x, r_origin_y;

    // item registers
    logic [KIND_W-1:0]       r_kind;
    logic signed [WK_W-1:0]  r_px, r_py;
    logic [RADIUS_W-1:0]     r_r;
    logic                    r_alpha_nz;

    // carve box and walk
    logic signed [WK_W-1:0]  r_ilo, r_jlo, r_ilast, r_jlast, r_i, r_j;
    logic signed [D_W-1:0]   r_dx0, r_dx, r_dy;
    logic [SQ_W-1:0]         r_dx2_0, r_dx2, r_dy2;
    logic [R2_W-1:0]         r_r2;
    logic [AW-1:0]           r_base, r_addr;

    // pixel waiting on its read data
    logic                    r_p_vld, r_p_in;
    logic [AW-1:0]           r_p_addr;

    logic [COUNT_W-1:0]      r_count;
    logic                    r_hit;
    logic [AW-1:0]           r_clr;

    // shared multiplier
    logic signed [WK_W-1:0]   mul_a, mul_b;
    logic signed [2*WK_W-1:0] r_prod;

    // result register
    logic                    r_out_vld, r_out_hit;
    logic [COUNT_W-1:0]      r_out_count;

    // memory port
    logic          mem_we, mem_wdata, mem_rdata;
    logic [AW-1:0] mem_waddr, mem_raddr, pix_addr;

    logic item_acc, res_load, pend_clr;

    // ------------------------------------------------------------------
    // handshakes
    assign i_cfg.ready         = 1'b1;
    assign i_item.ready        = (r_state == S_IDLE);
    assign item_acc            = i_item.valid && i_item.ready;
    assign res_load            = (r_state == S_RES) && (!r_out_vld || o_res.ready);
    assign o_res.valid         = r_out_vld;
    assign o_res.hit           = r_out_hit;
    assign o_res.cleared_count = r_out_count;

    // ------------------------------------------------------------------
    // prep: map test and clipped carve box
    logic signed [WK_W-1:0] rad_ext, lo_y, hi_y, lo_x, hi_x, ilo, ihi, jlo, jhi;
    logic signed [WK_W-1:0] dx0_w, dy0_w;
    logic in_map, box_empty;

    always_comb begin
        rad_ext   = $signed({{(WK_W-RADIUS_W){1'b0}}, r_r});
        lo_y      = r_py - rad_ext;
        hi_y      = r_py + rad_ext;
        lo_x      = r_px - rad_ext;
        hi_x      = r_px + rad_ext;
        ilo       = (lo_y < 0) ? '0 : lo_y;
        ihi       = (hi_y > MAP_H_S) ? MAP_H_S : hi_y;
        jlo       = (lo_x < 0) ? '0 : lo_x;
        jhi       = (hi_x > MAP_W_S) ? MAP_W_S : hi_x;
        box_empty = (ilo >= ihi) || (jlo >= jhi);
        dx0_w     = r_px - jlo;
        dy0_w     = r_py - ilo;
        in_map    = (r_px >= 0) && (r_py >= 0) && (r_px < MAP_W_S) && (r_py < MAP_H_S);
    end

    // ------------------------------------------------------------------
    // shared multiplier operand select, product registered
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MR: begin
                mul_a = rad_ext;
                mul_b = rad_ext;
            end
            S_MX: begin
                mul_a = WK_W'(r_dx0);
                mul_b = WK_W'(r_dx0);
            end
            S_MY: begin
                mul_a = WK_W'(r_dy);
                mul_b = WK_W'(r_dy);
            end
            S_MB: begin
                mul_a = r_ilo;
                mul_b = MAP_W_S;
            end
            S_ADDR: begin
                mul_a = r_py;
                mul_b = MAP_W_S;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // ------------------------------------------------------------------
    // walk arithmetic: squared distances stepped by (d-1)^2 = d^2 - 2d + 1
    logic signed [SQ_W+1:0] dx2_step, dy2_step;
    logic [SQ_W:0]          d2_sum;
    logic                   in_circle, last_col, last_row;

    always_comb begin
        dx2_step  = (SQ_W+2)'(1) + $signed({2'b00, r_dx2})
                    - ((SQ_W+2)'(r_dx) <<< 1);
        dy2_step  = (SQ_W+2)'(1) + $signed({2'b00, r_dy2})
                    - ((SQ_W+2)'(r_dy) <<< 1);
        d2_sum    = {1'b0, r_dx2} + {1'b0, r_dy2};
        in_circle = d2_sum <= {{(SQ_W+1-R2_W){1'b0}}, r_r2};
        last_col  = (r_j == r_jlast);
        last_row  = (r_i == r_ilast);
    end

    // ------------------------------------------------------------------
    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == LAST_A) n_state = S_IDLE;
            S_IDLE:  if (item_acc) n_state = S_PREP;
            S_PREP: begin
                if (r_kind == KIND_LOAD || r_kind == KIND_TEST) begin
                    n_state = in_map ? S_ADDR : S_RES;
                end else if (r_kind == KIND_CARVE) begin
                    n_state = box_empty ? S_RES : S_MR;
                end else begin
                    n_state = S_RES;
                end
            end
            S_ADDR:  n_state = S_ACC;
            S_ACC:   n_state = (r_kind == KIND_TEST) ? S_WAIT : S_RES;
            S_WAIT:  n_state = S_RES;
            S_MR:    n_state = S_MX;
            S_MX:    n_state = S_MY;
            S_MY:    n_state = S_MB;
            S_MB:    n_state = S_BASE;
            S_BASE:  n_state = S_ROW;
            S_ROW:   n_state = S_SCAN;
            S_SCAN: begin
                if (last_col) n_state = last_row ? S_DRAIN : S_ROW;
            end
            S_DRAIN: n_state = S_RES;
            S_RES:   if (res_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_p_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ORIGIN_X: r_origin_x <= i_cfg.data;
                    REG_ORIGIN_Y: r_origin_y <= i_cfg.data;
                    default:      r_origin_x <= r_origin_x;
                endcase
            end
            r_p_vld <= (r_state == S_SCAN);
            if (res_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    assign pend_clr = r_p_vld && r_p_in && mem_rdata;

    always_ff @(posedge i_clk) begin
        // take the word
        if (item_acc) begin
            r_kind     <= i_item.kind;
            r_r        <= i_item.radius;
            r_alpha_nz <= (i_item.pixel_alpha != '0);
            r_count    <= '0;
            r_hit      <= 1'b0;
            if (i_item.kind == KIND_LOAD) begin
                r_px <= WK_W'(i_item.x_coord);
                r_py <= WK_W'(i_item.y_coord);
            end else begin
                r_px <= WK_W'(i_item.x_coord) - WK_W'(r_origin_x);
                r_py <= WK_W'(i_item.y_coord) - WK_W'(r_origin_y);
            end
        end
        // box bounds
        if (r_state == S_PREP) begin
            r_ilo   <= ilo;
            r_i     <= ilo;
            r_jlo   <= jlo;
            r_ilast <= ihi - WK_W'(1);
            r_jlast <= jhi - WK_W'(1);
            r_dx0   <= D_W'(dx0_w);
            r_dy    <= D_W'(dy0_w);
        end
        // squares out of the shared multiplier
        if (r_state == S_MX)   r_r2    <= R2_W'($unsigned(r_prod));
        if (r_state == S_MY)   r_dx2_0 <= SQ_W'($unsigned(r_prod));
        if (r_state == S_MB)   r_dy2   <= SQ_W'($unsigned(r_prod));
        if (r_state == S_BASE) r_base  <= AW'($unsigned(r_prod));
        // row start
        if (r_state == S_ROW) begin
            r_addr <= r_base + AW'($unsigned(r_jlo));
            r_j    <= r_jlo;
            r_dx   <= r_dx0;
            r_dx2  <= r_dx2_0;
        end
        // pixel step, row step at the last column
        if (r_state == S_SCAN) begin
            r_p_in   <= in_circle;
            r_p_addr <= r_addr;
            r_addr   <= r_addr + AW'(1);
            r_j      <= r_j + WK_W'(1);
            r_dx     <= r_dx - D_W'(1);
            r_dx2    <= SQ_W'(dx2_step);
            if (last_col && !last_row) begin
                r_i    <= r_i + WK_W'(1);
                r_base <= r_base + AW'(MAP_W);
                r_dy   <= r_dy - D_W'(1);
                r_dy2  <= SQ_W'(dy2_step);
            end
        end
        // count cleared pixels, saturating
        if (pend_clr && r_count != COUNT_MAX) begin
            r_count <= r_count + COUNT_W'(1);
        end
        if (r_state == S_WAIT) begin
            r_hit <= mem_rdata;
        end
        if (res_load) begin
            r_out_hit   <= r_hit;
            r_out_count <= r_count;
        end
    end

    // ------------------------------------------------------------------
    // map RAM port control
    assign pix_addr = AW'($unsigned(r_prod)) + AW'($unsigned(r_px));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_p_addr;
        mem_wdata = 1'b0;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
        end else if (r_state == S_ACC && r_kind == KIND_LOAD) begin
            mem_we    = 1'b1;
            mem_waddr = pix_addr;
            mem_wdata = r_alpha_nz;
        end else if (pend_clr) begin
            mem_we    = 1'b1;
        end
        mem_raddr = (r_state == S_SCAN) ? r_addr : pix_addr;
    end

    bcmc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // ------------------------------------------------------------------
    // checks
    `BCMC_ASSERT_NXT(a_acc_to_prep, i_clk, i_rst_n, item_acc, r_state == S_PREP)
    `BCMC_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, mem_we && r_state == S_SCAN, mem_waddr != mem_raddr)
    `BCMC_ASSERT_IMP(a_pend_addr, i_clk, i_rst_n, r_p_vld, r_p_addr == $past(mem_raddr))
    `BCMC_ASSERT_IMP(a_count_carve, i_clk, i_rst_n, r_state == S_RES && r_kind != KIND_CARVE, r_count == '0)

endmodule

`default_nettype wire

@@ tb/collision_map_monitor.sv @@
// Monitor for the collision map carver: mirrors the map, predicts each result word and checks it.
`timescale 1ns / 1ps

module collision_map_monitor #(
    parameter int MAP_W = 256,
    parameter int MAP_H = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bcmc_cfg_if  i_cfg,
    bcmc_in_if   i_item,
    bcmc_out_if  i_res,
    output int   o_mismatches,
    output int   o_owed
);
    import bcmc_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] cleared;
    } t_map_word;

    // mirrored map: one packed row per map row, bit = column
    logic [MAP_W-1:0] solid_row [MAP_H];
    int               org_x;
    int               org_y;
    t_map_word        owed_words [$];
    t_map_word        got;
    t_map_word        want;

    function automatic bit on_map(int col, int row);
        return col >= 0 && row >= 0 && col < MAP_W && row < MAP_H;
    endfunction

    // clear solid pixels of the half-open box that fall inside the disc
    function automatic logic [COUNT_W-1:0] carve_disc(int cx, int cy, int r);
        int                 row_lo;
        int                 row_hi;
        int                 col_lo;
        int                 col_hi;
        int                 dx;
        int                 dy;
        logic [COUNT_W-1:0] n;
        n      = '0;
        row_lo = (cy - r < 0) ? 0 : cy - r;
        col_lo = (cx - r < 0) ? 0 : cx - r;
        row_hi = (cy + r > MAP_H) ? MAP_H : cy + r;
        col_hi = (cx + r > MAP_W) ? MAP_W : cx + r;
        for (int i = row_lo; i < row_hi; i++) begin
            for (int j = col_lo; j < col_hi; j++) begin
                dx = cx - j;
                dy = cy - i;
                if (solid_row[i][j] && dx * dx + dy * dy <= r * r) begin
                    solid_row[i][j] = 1'b0;
                    if (n != COUNT_MAX) n++;
                end
            end
        end
        return n;
    endfunction

    // apply one item to the mirrored map and return the word it should produce
    function automatic t_map_word step_map(logic [KIND_W-1:0] kind, int x, int y, int r,
                                           logic [ALPHA_W-1:0] alpha);
        t_map_word w;
        w = '0;
        case (kind)
            KIND_LOAD: begin
                if (on_map(x, y)) solid_row[y][x] = (alpha != '0);
            end
            KIND_CARVE: begin
                w.cleared = carve_disc(x - org_x, y - org_y, r);
            end
            KIND_TEST: begin
                if (on_map(x - org_x, y - org_y)) w.hit = solid_row[y - org_y][x - org_x];
            end
            default: ;
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (solid_row[i]) solid_row[i] = '0;
            org_x = 0;
            org_y = 0;
            owed_words.delete();
            o_mismatches = 0;
        end else begin
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ORIGIN_X: org_x = int'(i_cfg.data);
                    REG_ORIGIN_Y: org_y = int'(i_cfg.data);
                    default: ;
                endcase
            end
            // result words: checked before this edge's item is queued
            if (i_res.valid && i_res.ready) begin
                got.hit     = i_res.hit;
                got.cleared = i_res.cleared_count;
                if (owed_words.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected word: expected none, got hit %0b cleared %0d",
                             $time, got.hit, got.cleared);
                end else begin
                    want = owed_words.pop_front();
                    if (got.hit !== want.hit) begin
                        o_mismatches++;
                        $display("%0t: hit mismatch: expected %0b, got %0b",
                                 $time, want.hit, got.hit);
                    end
                    if (got.cleared !== want.cleared) begin
                        o_mismatches++;
                        $display("%0t: cleared_count mismatch: expected %0d, got %0d",
                                 $time, want.cleared, got.cleared);
                    end
                end
            end
            // accepted items
            if (i_item.valid && i_item.ready)
                owed_words.push_back(step_map(i_item.kind, int'(i_item.x_coord),
                                              int'(i_item.y_coord), int'(i_item.radius),
                                              i_item.pixel_alpha));
        end
        o_owed = owed_words.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the collision map carver: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
    import bcmc_pkg::*;

    localparam int MAP_W = 256;
    localparam int MAP_H = 256;
    localparam int SEGMENTS = 12;
    localparam int SEG_ITEMS = 42;
    // opcode the block leaves unused
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   items_sent;
    int   org_x;
    int   org_y;
    int   map_errors;
    int   words_owed;

    bcmc_cfg_if cfg_ch ();
    bcmc_in_if  item_ch ();
    bcmc_out_if res_ch ();

    bitmap_collision_map_carver #(
        .MAP_W(MAP_W),
        .MAP_H(MAP_H)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cfg  (cfg_ch),
        .i_item (item_ch),
        .o_res  (res_ch)
    );

    collision_map_monitor #(
        .MAP_W(MAP_W),
        .MAP_H(MAP_H)
    ) map_mon (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg       (cfg_ch),
        .i_item      (item_ch),
        .i_res       (res_ch),
        .o_mismatches(map_errors),
        .o_owed      (words_owed)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side back-pressure
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_ch.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // hard stop
    initial begin
        #50_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // offer one word, idling at random first, and wait for it to be taken
    task automatic push_item(logic [KIND_W-1:0] kind, int x, int y, int r, int a);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid       = 1'b1;
        item_ch.kind        = kind;
        item_ch.x_coord     = COORD_W'(x);
        item_ch.y_coord     = COORD_W'(y);
        item_ch.radius      = RADIUS_W'(r);
        item_ch.pixel_alpha = ALPHA_W'(a);
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // stop offering and wait until every owed word is back
    task automatic drain();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (words_owed != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = COORD_W'(value);
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_origin(int ox, int oy);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        org_x = ox;
        org_y = oy;
    endtask

    // test a point near a map position, in world coordinates
    task automatic probe(int mx, int my);
        push_item(KIND_TEST, mx + org_x + jitter(4), my + org_y + jitter(4),
                  $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // load a small patch, probe it, carve it, probe again
    task automatic run_cluster();
        int mx;
        int my;
        int r;
        mx = int'($urandom_range(0, 279)) - 12;
        my = int'($urandom_range(0, 279)) - 12;
        repeat ($urandom_range(3, 10))
            push_item(KIND_LOAD, mx + jitter(4), my + jitter(4), $urandom_range(0, 255),
                      ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 255));
        repeat ($urandom_range(1, 2)) probe(mx, my);
        r = ($urandom_range(39) == 0) ? $urandom_range(64, 255) : $urandom_range(0, 8);
        push_item(KIND_CARVE, mx + org_x + jitter(2), my + org_y + jitter(2), r,
                  $urandom_range(0, 255));
        repeat ($urandom_range(1, 3)) probe(mx, my);
    endtask

    initial begin
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_ORIGIN_X;
        cfg_ch.data          = '0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_LOAD;
        item_ch.x_coord      = '0;
        item_ch.y_coord      = '0;
        item_ch.radius       = '0;
        item_ch.pixel_alpha  = '0;
        src_idle_pct         = 24;
        snk_idle_pct         = 65;
        items_sent           = 0;
        org_x                = 0;
        org_y                = 0;
        rst_n                = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_origin(0, 0);

        // directed: map corners, off-map loads and tests, radius edge cases
        push_item(KIND_TEST, 0, 0, 0, 0);            // coordinate 0 is on the map
        push_item(KIND_LOAD, 0, 0, 0, 255);
        push_item(KIND_TEST, 0, 0, 0, 0);
        push_item(KIND_LOAD, 255, 255, 200, 1);      // radius ignored on load
        push_item(KIND_TEST, 255, 255, 255, 255);    // radius and alpha ignored on test
        push_item(KIND_LOAD, 256, 10, 0, 5);         // off-map loads are dropped
        push_item(KIND_LOAD, -1, 10, 0, 5);
        push_item(KIND_LOAD, 10, -2048, 0, 128);
        push_item(KIND_LOAD, 2047, 2047, 0, 255);
        push_item(KIND_TEST, 256, 10, 0, 0);         // off-map tests miss
        push_item(KIND_TEST, -1, -1, 0, 0);
        push_item(KIND_LOAD, 0, 0, 0, 0);            // zero alpha clears
        push_item(KIND_TEST, 0, 0, 0, 0);
        push_item(KIND_LOAD, 5, 5, 0, 128);
        push_item(KIND_LOAD, 6, 5, 0, 128);
        push_item(KIND_LOAD, 5, 6, 0, 128);
        push_item(KIND_CARVE, 5, 5, 0, 0);           // zero radius clears nothing
        push_item(KIND_CARVE, 5, 5, 1, 0);           // box is half-open: only the centre
        push_item(KIND_CARVE, 128, 128, 255, 255);   // widest disc, whole map
        push_item(KIND_TEST, 6, 5, 0, 0);
        push_item(KIND_SPARE, 7, 7, 255, 255);       // unused opcode
        push_item(KIND_CARVE, -2048, 2047, 255, 255);
        push_item(KIND_TEST, 2047, -2048, 0, 0);

        // random segments, each under its own origin
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < SEGMENTS / 3) begin
                src_idle_pct = 24;
                snk_idle_pct = 65;
            end else if (seg < 2 * SEGMENTS / 3) begin
                src_idle_pct = 65;
                snk_idle_pct = 24;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            drain();
            case (seg % 6)
                0: set_origin(0, 0);
                1: set_origin(jitter(64), jitter(64));
                2: set_origin(-2048, 2047);
                3: set_origin(jitter(2048), jitter(2048));
                4: set_origin(2047, -2048);
                default: set_origin(jitter(300), jitter(300));
            endcase
            for (int stop = items_sent + SEG_ITEMS; items_sent < stop; ) begin
                if ($urandom_range(4) == 0)
                    push_item(KIND_W'($urandom_range(0, 3)), $urandom, $urandom,
                              $urandom_range(0, 255), $urandom_range(0, 255));
                else
                    run_cluster();
            end
        end

        drain();
        repeat (64) @(negedge clk);
        if (map_errors == 0 && words_owed == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ bitmap_collision_map_carver.f @@
+incdir+hdl
hdl/bcmc_pkg.sv
hdl/bcmc_if.sv
hdl/bcmc_ram.sv
hdl/bitmap_collision_map_carver.sv
tb/collision_map_monitor.sv
tb/tb_top.sv
